// File: rtl/core/strided_array_bounds_check_macros.svh
// ----------------------------------------------------------------------------
// strided array bounds check assertion macros
// shared property forms for the checker pipeline
// ----------------------------------------------------------------------------
`ifndef STRIDED_ARRAY_BOUNDS_CHECK_MACROS_SVH
`define STRIDED_ARRAY_BOUNDS_CHECK_MACROS_SVH

// same-cycle implication
`define SABC_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SABC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sabc_pkg.sv
// ----------------------------------------------------------------------------
// sabc_pkg
// shared types and constants of the strided array bounds check
// ----------------------------------------------------------------------------
package sabc_pkg;

   localparam int MAX_RANK     = 4;
   localparam int CARRIED_DIMS = 4;
   localparam int NUM_STAGES   = 10;
   localparam int REQ_TDATA_W  = 616;
   localparam int RSP_TDATA_W  = 8;

   // request payload, lowest field last
   typedef struct packed {
      logic [4:0]  pad;
      logic [63:0] step_3;
      logic [63:0] step_2;
      logic [63:0] step_1;
      logic [63:0] step_0;
      logic [63:0] extent_3;
      logic [63:0] extent_2;
      logic [63:0] extent_1;
      logic [63:0] extent_0;
      logic [63:0] byte_limit;
      logic [31:0] item_bytes;
      logic [2:0]  dim_count;
   } sabc_req_type;

   // per-request flags and operands carried down the pipe
   typedef struct packed {
      logic        fail;
      logic        empty;
      logic        big_rank;
      logic        span_bad;
      logic [31:0] item;
      logic [63:0] limit;
   } sabc_side_type;

   typedef struct packed {
      logic load;
      logic finish;
   } sabc_mul_en_type;

endpackage

// File: rtl/core/sabc_mul_ovf.sv
// ----------------------------------------------------------------------------
// sabc_mul_ovf
// two-stage 64 x 64 unsigned multiply, low 64 bits and overflow flag
// ----------------------------------------------------------------------------
module sabc_mul_ovf (
   input  logic                       clock,
   input  sabc_pkg::sabc_mul_en_type  en,
   input  logic [63:0]                a,
   input  logic [63:0]                b,
   output logic [63:0]                prod,
   output logic                       ovf
);

   logic [31:0] a_hi;
   logic [31:0] a_lo;
   logic [31:0] b_hi;
   logic [31:0] b_lo;
   logic [31:0] x_op;
   logic [31:0] y_op;
   logic [63:0] ll_in;
   logic [63:0] cross_in;
   logic        hh_in;
   logic [64:0] high;

   logic [63:0] ll_ff;
   logic [63:0] cross_ff;
   logic        hh_ff;
   logic [63:0] prod_ff;
   logic        ovf_ff;

   always_comb begin
      a_hi     = a[63:32];
      a_lo     = a[31:0];
      b_hi     = b[63:32];
      b_lo     = b[31:0];
      // only one cross term can be nonzero unless both high halves are set
      x_op     = (a_hi != 32'd0) ? a_hi : a_lo;
      y_op     = (a_hi != 32'd0) ? b_lo : b_hi;
      ll_in    = 64'(a_lo) * 64'(b_lo);
      cross_in = 64'(x_op) * 64'(y_op);
      hh_in    = (a_hi != 32'd0) && (b_hi != 32'd0);
      high     = 65'(cross_ff) + 65'(ll_ff[63:32]);
   end

   always_ff @(posedge clock) begin
      if (en.load) begin
         ll_ff    <= ll_in;
         cross_ff <= cross_in;
         hh_ff    <= hh_in;
      end
      if (en.finish) begin
         prod_ff <= {high[31:0], ll_ff[31:0]};
         ovf_ff  <= hh_ff || (high[64:32] != 33'd0);
      end
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule

// File: rtl/core/strided_array_bounds_check.sv
// ----------------------------------------------------------------------------
// strided_array_bounds_check
// pipelined check of a strided array descriptor ahead of a dma transfer
//
// req_* carries one descriptor per request, rsp_* returns one pass flag per
// request in the same order. a request is taken whenever req_tvalid and
// req_tready are high; one request per cycle is sustained while rsp_tready
// stays high. a request passes one decode stage, three 64-bit multiplies of
// the element count and one by the element size (two stages each), and the
// final limit compare; rsp_tvalid is the valid bit of that last stage.
// when rsp_tready is low the pipe compacts: requests keep entering until
// every stage holds one, then req_tready drops; nothing is lost or repeated.
// reset clears all stage valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
`include "strided_array_bounds_check_macros.svh"

module strided_array_bounds_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // dim_count, item_bytes, byte_limit, extent_0..3, step_0..3, zero pad
   input  logic [sabc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // descriptor_ok, zero pad
   output logic [sabc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   sabc_pkg::sabc_req_type   req_w;
   logic [3:0]               in_rank;
   logic [63:0]              ext_w [4];
   logic [63:0]              stp_w [4];
   logic [63:0]              ext_in [4];
   logic [63:0]              opa_in [4];
   logic [63:0]              opb_in [4];

   logic [sabc_pkg::NUM_STAGES:1] valid_ff;
   logic [sabc_pkg::NUM_STAGES:1] stage_en;
   logic                          pipe_full;
   logic                          tail_stall;

   sabc_pkg::sabc_side_type  side_in [1:9];
   sabc_pkg::sabc_side_type  side_ff [1:9];

   logic [63:0] ext_ff  [4];
   logic [63:0] opa_ff  [4];
   logic [63:0] opb_ff  [4];
   logic [63:0] ext2_ff [2:3];
   logic [63:0] ext3_ff [2:5];

   logic [63:0] term_w  [4];
   logic [3:0]  term_ovf_w;
   logic [64:0] sum01_ff;
   logic [64:0] sum23_ff;
   logic        span_ovf4_ff;
   logic [65:0] sum5_ff;
   logic        span_ovf5_ff;
   logic [66:0] sum6_ff;
   logic        span_ovf6_ff;

   logic [63:0] prod_a;
   logic [63:0] prod_b;
   logic [63:0] prod_c;
   logic [63:0] prod_d;
   logic        ovf_a;
   logic        ovf_b;
   logic        ovf_c;
   logic        ovf_d;
   logic [63:0] bytes_a;

   logic        ok_in;
   logic        ok_ff;

   sabc_pkg::sabc_mul_en_type en_s2;
   sabc_pkg::sabc_mul_en_type en_s4;
   sabc_pkg::sabc_mul_en_type en_s6;
   sabc_pkg::sabc_mul_en_type en_s8;

   assign req_w = req_tdata;

   // stage advance, a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[sabc_pkg::NUM_STAGES] = !valid_ff[sabc_pkg::NUM_STAGES] || rsp_tready;
      for (int k = sabc_pkg::NUM_STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            valid_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= sabc_pkg::NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // decode: rank checks, masked extents, span operands
   always_comb begin
      ext_w[0] = req_w.extent_0;
      ext_w[1] = req_w.extent_1;
      ext_w[2] = req_w.extent_2;
      ext_w[3] = req_w.extent_3;
      stp_w[0] = req_w.step_0;
      stp_w[1] = req_w.step_1;
      stp_w[2] = req_w.step_2;
      stp_w[3] = req_w.step_3;

      side_in[1].fail     = 32'(req_w.dim_count) > 32'(sabc_pkg::MAX_RANK);
      side_in[1].big_rank = 32'(req_w.dim_count) > 32'(sabc_pkg::CARRIED_DIMS);
      side_in[1].empty    = side_in[1].big_rank;
      side_in[1].span_bad = 1'b0;
      side_in[1].item     = req_w.item_bytes;
      side_in[1].limit    = req_w.byte_limit;

      for (int i = 0; i < sabc_pkg::CARRIED_DIMS; i++) begin
         in_rank[i] = 32'(req_w.dim_count) > 32'(i);
         ext_in[i]  = in_rank[i] ? ext_w[i] : 64'd1;
         opa_in[i]  = ext_w[i] - 64'd1;
         opb_in[i]  = in_rank[i] ? stp_w[i] : 64'd0;
         if (!in_rank[i] && ((ext_w[i] != 64'd0) || (stp_w[i] != 64'd0))) begin
            side_in[1].fail = 1'b1;
         end
         if (in_rank[i] && (ext_w[i] == 64'd0)) begin
            side_in[1].empty = 1'b1;
         end
      end
   end

   // flag merging as requests move down
   always_comb begin
      side_in[2]          = side_ff[1];
      side_in[3]          = side_ff[2];
      side_in[4]          = side_ff[3];
      side_in[5]          = side_ff[4];
      side_in[6]          = side_ff[5];
      side_in[7]          = side_ff[6];
      side_in[8]          = side_ff[7];
      side_in[9]          = side_ff[8];
      side_in[4].fail     = side_ff[3].fail || ovf_a;
      side_in[6].fail     = side_ff[5].fail || ovf_b;
      side_in[7].span_bad = span_ovf6_ff || (sum6_ff[66:64] != 3'd0)
                            || (sum6_ff[63:0] > side_ff[6].limit);
      side_in[8].fail     = side_ff[7].fail || ovf_c;
   end

   assign bytes_a = side_ff[7].big_rank ? 64'd0 : prod_c;

   assign ok_in = !(side_ff[9].fail || ovf_d || (prod_d > side_ff[9].limit)
                    || (!side_ff[9].empty && side_ff[9].span_bad));

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         side_ff[1] <= side_in[1];
         for (int i = 0; i < sabc_pkg::CARRIED_DIMS; i++) begin
            ext_ff[i] <= ext_in[i];
            opa_ff[i] <= opa_in[i];
            opb_ff[i] <= opb_in[i];
         end
      end
      for (int k = 2; k <= 9; k++) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_in[k];
         end
      end
      if (stage_en[2]) begin
         ext2_ff[2] <= ext_ff[2];
         ext3_ff[2] <= ext_ff[3];
      end
      if (stage_en[3]) begin
         ext2_ff[3] <= ext2_ff[2];
         ext3_ff[3] <= ext3_ff[2];
      end
      if (stage_en[4]) begin
         ext3_ff[4]   <= ext3_ff[3];
         sum01_ff     <= 65'(term_w[0]) + 65'(term_w[1]);
         sum23_ff     <= 65'(term_w[2]) + 65'(term_w[3]);
         span_ovf4_ff <= |term_ovf_w;
      end
      if (stage_en[5]) begin
         ext3_ff[5]   <= ext3_ff[4];
         sum5_ff      <= 66'(sum01_ff) + 66'(sum23_ff);
         span_ovf5_ff <= span_ovf4_ff;
      end
      if (stage_en[6]) begin
         sum6_ff      <= 67'(sum5_ff) + 67'(side_ff[5].item);
         span_ovf6_ff <= span_ovf5_ff;
      end
      if (stage_en[10]) begin
         ok_ff <= ok_in;
      end
   end

   assign en_s2 = '{load: stage_en[2], finish: stage_en[3]};
   assign en_s4 = '{load: stage_en[4], finish: stage_en[5]};
   assign en_s6 = '{load: stage_en[6], finish: stage_en[7]};
   assign en_s8 = '{load: stage_en[8], finish: stage_en[9]};

   // span terms (extent - 1) * stride
   for (genvar g = 0; g < sabc_pkg::CARRIED_DIMS; g++) begin : g_term
      sabc_mul_ovf u_term (
         .clock (clock),
         .en    (en_s2),
         .a     (opa_ff[g]),
         .b     (opb_ff[g]),
         .prod  (term_w[g]),
         .ovf   (term_ovf_w[g])
      );
   end

   // element count chain, then bytes
   sabc_mul_ovf u_mul_a (
      .clock (clock),
      .en    (en_s2),
      .a     (ext_ff[0]),
      .b     (ext_ff[1]),
      .prod  (prod_a),
      .ovf   (ovf_a)
   );

   sabc_mul_ovf u_mul_b (
      .clock (clock),
      .en    (en_s4),
      .a     (prod_a),
      .b     (ext2_ff[3]),
      .prod  (prod_b),
      .ovf   (ovf_b)
   );

   sabc_mul_ovf u_mul_c (
      .clock (clock),
      .en    (en_s6),
      .a     (prod_b),
      .b     (ext3_ff[5]),
      .prod  (prod_c),
      .ovf   (ovf_c)
   );

   sabc_mul_ovf u_mul_d (
      .clock (clock),
      .en    (en_s8),
      .a     (bytes_a),
      .b     ({32'd0, side_ff[7].item}),
      .prod  (prod_d),
      .ovf   (ovf_d)
   );

   assign rsp_tvalid = valid_ff[sabc_pkg::NUM_STAGES];
   assign rsp_tdata  = {(sabc_pkg::RSP_TDATA_W - 1)'(0), ok_ff};

   assign pipe_full  = &valid_ff;
   assign tail_stall = valid_ff[sabc_pkg::NUM_STAGES] && !rsp_tready
                       && valid_ff[sabc_pkg::NUM_STAGES-1];

   `SABC_ASSERT_HOLDS(a_ready_on_bubble, !pipe_full, req_tready, "refused with a free stage")
   `SABC_ASSERT_HOLDS(a_full_stall, pipe_full && !rsp_tready, !req_tready, "taken while full")
   `SABC_ASSERT_NEXT(a_tail_held, tail_stall, valid_ff[sabc_pkg::NUM_STAGES-1], "request lost")

endmodule

// File: bench/bounds_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounds_verdict_checker
// watches both streams of the strided array bounds check, works out the pass
// flag of every accepted descriptor and compares it, in order, with the
// flags that come back
// ----------------------------------------------------------------------------
module bounds_verdict_checker
   import sabc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata,
   output int                      mismatch_count,
   output int                      outstanding,
   output int                      verdicts_checked,
   output int                      verdicts_passed
);

   logic awaited_verdicts[$];
   int   mismatches = 0;
   int   pending    = 0;
   int   checked    = 0;
   int   passed     = 0;

   assign mismatch_count   = mismatches;
   assign outstanding      = pending;
   assign verdicts_checked = checked;
   assign verdicts_passed  = passed;

   task automatic report_mismatch(input string what);
      if (mismatches < 25) begin
         $display("[%0t] bounds check: %s", $time, what);
      end
      mismatches++;
   endtask

   function automatic logic descriptor_fits(input sabc_req_type d);
      logic [63:0]  ext [CARRIED_DIMS];
      logic [63:0]  stp [CARRIED_DIMS];
      logic [127:0] wide;
      logic [63:0]  count;
      logic [63:0]  reach;
      logic [63:0]  span;
      logic [63:0]  e;
      logic [63:0]  s;
      logic         hollow;
      int unsigned  rank;
      ext[0] = d.extent_0;
      ext[1] = d.extent_1;
      ext[2] = d.extent_2;
      ext[3] = d.extent_3;
      stp[0] = d.step_0;
      stp[1] = d.step_1;
      stp[2] = d.step_2;
      stp[3] = d.step_3;
      rank   = d.dim_count;
      if (rank > MAX_RANK) return 1'b0;
      for (int k = rank; k < CARRIED_DIMS; k++) begin
         if (ext[k] != 64'd0 || stp[k] != 64'd0) return 1'b0;
      end
      count  = 64'd1;
      hollow = 1'b0;
      for (int k = 0; k < rank; k++) begin
         e    = (k < CARRIED_DIMS) ? ext[k] : 64'd0;
         wide = 128'(count) * 128'(e);
         if (wide[127:64] != 64'd0) return 1'b0;
         count = wide[63:0];
         if (e == 64'd0) hollow = 1'b1;
      end
      wide = 128'(count) * 128'(d.item_bytes);
      if (wide[127:64] != 64'd0) return 1'b0;
      if (wide[63:0] > d.byte_limit) return 1'b0;
      if (!hollow) begin
         span = 64'd0;
         for (int k = 0; k < rank; k++) begin
            e    = (k < CARRIED_DIMS) ? ext[k] : 64'd0;
            s    = (k < CARRIED_DIMS) ? stp[k] : 64'd0;
            wide = 128'(e - 64'd1) * 128'(s);
            if (wide[127:64] != 64'd0) return 1'b0;
            reach = wide[63:0];
            wide  = 128'(span) + 128'(reach);
            if (wide[64]) return 1'b0;
            span = wide[63:0];
         end
         wide = 128'(span) + 128'(d.item_bytes);
         if (wide[64]) return 1'b0;
         if (wide[63:0] > d.byte_limit) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_verdicts.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_tdata[0] !== want) begin
                  report_mismatch($sformatf("response %0d: descriptor_ok %b, expected %b",
                                            checked, rsp_tdata[0], want));
               end
               checked++;
               if (want) passed++;
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_verdicts.push_back(descriptor_fits(sabc_req_type'(req_tdata)));
         end
         pending = awaited_verdicts.size();
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives strided array descriptors into the bounds check: a directed set of
// corner descriptors under a long output stall, then random descriptors that
// are mostly well formed, with random gaps on both streams; the checker
// beside the block predicts and compares every pass flag
// ----------------------------------------------------------------------------
module testbench;
   import sabc_pkg::*;

   localparam int          TOTAL_REQUESTS  = 1850;
   localparam int          CALM_TAIL       = 150;
   localparam int          HOLD_OFF_CYCLES = 60;
   localparam logic [63:0] ALL_ONES        = '1;
   localparam logic [63:0] TOP_BIT         = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TWO_POW_32      = 64'h1_0000_0000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   bit calm = 1'b0;
   int sent = 0;
   int directed_count = 0;
   int mismatches;
   int outstanding;
   int verdicts_checked;
   int verdicts_passed;

   strided_array_bounds_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bounds_verdict_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatches),
      .outstanding      (outstanding),
      .verdicts_checked (verdicts_checked),
      .verdicts_passed  (verdicts_passed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic sabc_req_type descriptor(
      input logic [2:0]  rank,
      input logic [31:0] item,
      input logic [63:0] limit,
      input logic [63:0] e0, e1, e2, e3,
      input logic [63:0] s0, s1, s2, s3
   );
      sabc_req_type d;
      d            = '0;
      d.dim_count  = rank;
      d.item_bytes = item;
      d.byte_limit = limit;
      d.extent_0   = e0;
      d.extent_1   = e1;
      d.extent_2   = e2;
      d.extent_3   = e3;
      d.step_0     = s0;
      d.step_1     = s1;
      d.step_2     = s2;
      d.step_3     = s3;
      return d;
   endfunction

   function automatic logic [63:0] pick_magnitude();
      case ($urandom_range(0, 9))
         0:          return 64'd0;
         1, 2, 3, 4: return 64'($urandom_range(1, 16));
         5, 6:       return 64'($urandom_range(1, 65535));
         7:          return {$urandom, $urandom} >> $urandom_range(0, 63);
         8:          return 64'd1 << $urandom_range(0, 63);
         default:    return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_descriptor(output sabc_req_type d);
      logic [63:0]  ext [CARRIED_DIMS];
      logic [63:0]  stp [CARRIED_DIMS];
      logic [255:0] count;
      logic [255:0] reach_sum;
      logic [255:0] need;
      logic [63:0]  footprint;
      logic [63:0]  limit;
      logic [31:0]  item;
      int unsigned  rank;
      int unsigned  kind;
      int unsigned  k;
      kind      = $urandom_range(0, 19);
      rank      = $urandom_range(0, MAX_RANK);
      count     = 256'd1;
      reach_sum = 256'd0;
      for (k = 0; k < CARRIED_DIMS; k++) begin
         ext[k] = (k < rank) ? pick_magnitude() : 64'd0;
         stp[k] = (k < rank) ? pick_magnitude() : 64'd0;
         if (k < rank) begin
            count     = count * 256'(ext[k]);
            reach_sum = reach_sum + (256'(ext[k]) - 256'd1) * 256'(stp[k]);
         end
      end
      case ($urandom_range(0, 3))
         0:       item = 32'($urandom_range(1, 16));
         1:       item = 32'd1 << $urandom_range(0, 31);
         2:       item = $urandom;
         default: item = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      endcase
      need = count * 256'(item);
      if (reach_sum + 256'(item) > need) need = reach_sum + 256'(item);
      footprint = (need[255:64] != 0) ? ALL_ONES : need[63:0];
      case ($urandom_range(0, 5))
         0:       limit = ALL_ONES;
         1:       limit = {$urandom, $urandom} >> $urandom_range(0, 63);
         2:       limit = footprint - 64'd1;
         3:       limit = footprint + 64'd1;
         default: limit = footprint;
      endcase
      if (kind >= 14 && kind <= 16) begin
         // broken: stray field past the rank, or a rank above the maximum
         if (rank < CARRIED_DIMS && $urandom_range(0, 2) != 0) begin
            k = $urandom_range(rank, CARRIED_DIMS - 1);
            if ($urandom_range(0, 1)) begin
               ext[k][$urandom_range(0, 63)] = 1'b1;
            end else begin
               stp[k][$urandom_range(0, 63)] = 1'b1;
            end
         end else begin
            rank = $urandom_range(MAX_RANK + 1, 7);
         end
      end else if (kind > 16) begin
         // noise
         rank  = $urandom_range(0, 7);
         item  = $urandom;
         limit = {$urandom, $urandom};
         for (k = 0; k < CARRIED_DIMS; k++) begin
            ext[k] = {$urandom, $urandom};
            stp[k] = {$urandom, $urandom};
         end
      end
      d = descriptor(3'(rank), item, limit, ext[0], ext[1], ext[2], ext[3],
                     stp[0], stp[1], stp[2], stp[3]);
   endtask

   task automatic offer(input sabc_req_type d);
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // response side: long hold-off first so the pipe fills, then random stalls
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      sabc_req_type d;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero rank
      offer(descriptor(3'd0, 32'd0, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(descriptor(3'd0, 32'd1, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(descriptor(3'd0, 32'hFFFF_FFFF, ALL_ONES, 0, 0, 0, 0, 0, 0, 0, 0));
      // rank above the maximum
      offer(descriptor(3'd5, 32'd1, ALL_ONES, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(descriptor(3'd7, 32'd1, ALL_ONES, 1, 1, 1, 1, 0, 0, 0, 0));
      // full rank, unit extents
      offer(descriptor(3'd4, 32'd4, 64'd4, 1, 1, 1, 1, 0, 0, 0, 0));
      // stray extent or stride past the rank
      offer(descriptor(3'd2, 32'd1, ALL_ONES, 2, 2, 1, 0, 1, 1, 0, 0));
      offer(descriptor(3'd3, 32'd1, ALL_ONES, 2, 2, 2, 0, 1, 1, 1, TOP_BIT));
      // element count overflow, also ahead of an empty dimension
      offer(descriptor(3'd2, 32'd1, ALL_ONES, TWO_POW_32, TWO_POW_32, 0, 0,
                       0, 0, 0, 0));
      offer(descriptor(3'd3, 32'd1, ALL_ONES, TWO_POW_32, TWO_POW_32, 0, 0,
                       0, 0, 0, 0));
      // empty array skips the span check
      offer(descriptor(3'd2, 32'd8, 64'd0, 0, 5, 0, 0, ALL_ONES, ALL_ONES, 0, 0));
      // byte count overflow
      offer(descriptor(3'd1, 32'd2, ALL_ONES, ALL_ONES, 0, 0, 0, 2, 0, 0, 0));
      // byte count at and just past the limit
      offer(descriptor(3'd2, 32'd4, 64'd48, 3, 4, 0, 0, 16, 4, 0, 0));
      offer(descriptor(3'd2, 32'd4, 64'd47, 3, 4, 0, 0, 16, 4, 0, 0));
      // span over the limit while the byte count fits
      offer(descriptor(3'd1, 32'd4, 64'd8, 2, 0, 0, 0, 100, 0, 0, 0));
      offer(descriptor(3'd1, 32'd4, 64'd104, 2, 0, 0, 0, 100, 0, 0, 0));
      // reach multiply overflow
      offer(descriptor(3'd1, 32'd1, ALL_ONES, 3, 0, 0, 0, TOP_BIT, 0, 0, 0));
      // span sum overflow, and overflow adding the element size
      offer(descriptor(3'd2, 32'd0, ALL_ONES, 2, 2, 0, 0, TOP_BIT, TOP_BIT, 0, 0));
      offer(descriptor(3'd1, 32'd1, ALL_ONES, 2, 0, 0, 0, ALL_ONES, 0, 0, 0));
      // unit extent with the widest stride reaches nothing
      offer(descriptor(3'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 1, 0, 0, 0,
                       ALL_ONES, 0, 0, 0));
      // widest extents and strides at full rank
      offer(descriptor(3'd4, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES,
                       ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      offer(descriptor(3'd4, 32'd2, ALL_ONES, 16, 8, 4, 2, 128, 16, 4, 2));
      directed_count = sent;

      while (sent < TOTAL_REQUESTS) begin
         if (sent >= TOTAL_REQUESTS - CALM_TAIL) calm = 1'b1;
         random_descriptor(d);
         offer(d);
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (3 * NUM_STAGES) @(negedge clock);

      $display("covered %0d descriptors (%0d directed, %0d random) with stalls on both sides",
               sent, directed_count, sent - directed_count);
      $display("%0d flags compared: %0d passing, %0d rejected; pipe backed up under a %0d-cycle hold",
               verdicts_checked, verdicts_passed, verdicts_checked - verdicts_passed,
               HOLD_OFF_CYCLES);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("run timed out with %0d flags outstanding", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: strided_array_bounds_check.f
+incdir+rtl/core
rtl/core/sabc_pkg.sv
rtl/core/sabc_mul_ovf.sv
rtl/core/strided_array_bounds_check.sv
bench/bounds_verdict_checker.sv
bench/testbench.sv
